FILE: rtl/core/per_flow_latency_window_stats_assert.svh
// assertion macros for the checker file
`ifndef PER_FLOW_LATENCY_WINDOW_STATS_ASSERT_SVH
`define PER_FLOW_LATENCY_WINDOW_STATS_ASSERT_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define PLWS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define PLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/plws_pkg.sv
// types and constants of the per-flow latency window statistics block
package plws_pkg;

  localparam int SLOTS    = 32;
  localparam int ID_WIDTH = 16;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [7:0] WINDOW_RESET = 8'd30;

  typedef struct packed {
    logic        sampled;
    logic [1:0]  output_kind;
    logic [15:0] output_id;
    logic [15:0] stream_id;
    logic [1:0]  media_kind;
    logic [63:0] capture_ts_us;
    logic [63:0] qin_ts_us;
    logic [63:0] tx_begin_us;
    logic [63:0] tx_end_us;
    logic [63:0] encode_time_us;
  } plws_in_t;

  typedef struct packed {
    logic [63:0] e2e_us;
    logic [63:0] queue_wait_us;
    logic [63:0] send_us;
    logic [4:0]  slot_index;
    logic        no_slot;
    logic        window_done;
    logic [7:0]  window_samples;
    logic [63:0] sum_e2e_us;
    logic [63:0] sum_encode_us;
    logic [63:0] sum_queue_us;
    logic [63:0] sum_send_us;
  } plws_out_t;

  // flow key as held in the slot directory
  typedef struct packed {
    logic [1:0]          output_kind;
    logic [1:0]          media_kind;
    logic [ID_WIDTH-1:0] output_id;
    logic [ID_WIDTH-1:0] stream_id;
  } plws_key_t;

  // one entry of the slot accumulator memory
  typedef struct packed {
    logic [7:0]  count;
    logic [63:0] sum_e2e;
    logic [63:0] sum_encode;
    logic [63:0] sum_queue;
    logic [63:0] sum_send;
  } plws_acc_t;

  // directory answer for the current key
  typedef struct packed {
    logic              hit;
    logic              full;
    logic [SLOT_W-1:0] idx;
  } plws_lookup_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ACC
  } plws_state_e;

  function automatic plws_key_t plws_key_of(plws_in_t item);
    logic [31:0] oid;
    logic [31:0] sid;
    plws_key_t   k;
    oid = 32'(item.output_id);
    sid = 32'(item.stream_id);
    k.output_kind = item.output_kind;
    k.media_kind  = item.media_kind;
    k.output_id   = oid[ID_WIDTH-1:0];
    k.stream_id   = sid[ID_WIDTH-1:0];
    return k;
  endfunction

endpackage

FILE: rtl/core/plws_ram.sv
// generic single-write, single-read ram with registered read data
module plws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/plws_slot_dir.sv
// flow slot directory: used marks, stored keys and parallel key match
module plws_slot_dir import plws_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plws_key_t         key_i,
  input  logic              alloc_i,
  input  logic [SLOT_W-1:0] alloc_idx_i,
  output plws_lookup_t      lookup_o
);

  logic [SLOTS-1:0] used_q;
  plws_key_t        key_q [SLOTS];
  logic [SLOTS-1:0] match;
  logic             hit;
  logic             any_free;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (alloc_i) begin
      used_q[alloc_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      key_q[alloc_idx_i] <= key_i;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = used_q[i] && (key_q[i] == key_i);
    end
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used_q[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    lookup_o.hit  = hit;
    lookup_o.full = !hit && !any_free;
    lookup_o.idx  = hit ? hit_idx : free_idx;
  end

endmodule

FILE: rtl/core/per_flow_latency_window_stats.sv
// top level of the per-flow latency window statistics block
//
//   port group   kind              payload
//   in_*         valid/ready       plws_in_t (timestamps and flow key)
//   out_*        valid/ready       plws_out_t (latencies, slot, window report)
//   cfg_*        write enable      window_size, 8 bits
//
// a sampled item goes through key match and slot memory read, then
// accumulate and write back through the one-port-each slot memory.
// an unsampled item is taken without a lookup and gives no result.
// the next item is taken in the cycle its predecessor finishes.
// a stalled output holds the block in the accumulate step.
// reset clears the used marks at once; there is no clearing pass.
module per_flow_latency_window_stats import plws_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  plws_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output plws_out_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int AccW = $bits(plws_acc_t);

  plws_state_e  state_q, state_d;
  plws_in_t     in_q;
  plws_lookup_t look_q;
  plws_lookup_t lookup;
  logic         alloc_q;
  logic [63:0]  e2e_q, qw_q, snd_q;
  logic [7:0]   window_size_q;
  logic         out_valid_q;
  plws_out_t    out_q;

  logic         in_accept;
  logic         finish;
  logic         alloc;
  logic [64:0]  e2e_diff, qw_diff;
  logic [AccW-1:0] ram_rdata;
  plws_acc_t    base, upd, wdata;
  logic         done;
  plws_out_t    res;

  // ---------------- control
  assign finish    = (state_q == ST_ACC) && (!out_valid_q || out_ready_i);
  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_item_i.sampled) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        in_ready_o = finish;
        if (finish) begin
          state_d = (in_valid_i && in_item_i.sampled) ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  // ---------------- lookup step
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  assign alloc = (state_q == ST_LOOK) && !lookup.hit && !lookup.full;

  plws_slot_dir u_slot_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (plws_key_of(in_q)),
    .alloc_i     (alloc),
    .alloc_idx_i (lookup.idx),
    .lookup_o    (lookup)
  );

  assign e2e_diff = {1'b0, in_q.tx_end_us} - {1'b0, in_q.capture_ts_us};
  assign qw_diff  = {1'b0, in_q.tx_begin_us} - {1'b0, in_q.qin_ts_us};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      look_q  <= lookup;
      alloc_q <= alloc;
      e2e_q   <= e2e_diff[64] ? '0 : e2e_diff[63:0];
      qw_q    <= qw_diff[64] ? '0 : qw_diff[63:0];
      snd_q   <= in_q.tx_end_us - in_q.tx_begin_us;
    end
  end

  // ---------------- accumulate step
  plws_ram #(
    .WIDTH (AccW),
    .DEPTH (SLOTS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (finish && !look_q.full),
    .waddr_i (look_q.idx),
    .wdata_i (wdata),
    .raddr_i (lookup.idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // a newly taken slot starts from zero
    base            = alloc_q ? '0 : plws_acc_t'(ram_rdata);
    upd.count       = base.count + 8'd1;
    upd.sum_e2e     = base.sum_e2e + e2e_q;
    upd.sum_encode  = base.sum_encode + in_q.encode_time_us;
    upd.sum_queue   = base.sum_queue + qw_q;
    upd.sum_send    = base.sum_send + snd_q;
    done            = upd.count >= window_size_q;
    wdata           = done ? '0 : upd;

    res                = '0;
    res.e2e_us         = e2e_q;
    res.queue_wait_us  = qw_q;
    res.send_us        = snd_q;
    res.no_slot        = look_q.full;
    if (!look_q.full) begin
      res.slot_index = 5'(look_q.idx);
      if (done) begin
        res.window_done    = 1'b1;
        res.window_samples = upd.count;
        res.sum_e2e_us     = upd.sum_e2e;
        res.sum_encode_us  = upd.sum_encode;
        res.sum_queue_us   = upd.sum_queue;
        res.sum_send_us    = upd.sum_send;
      end
    end
  end

  // ---------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/core/plws_checker.sv
// port-level checker for the per-flow latency window statistics block
`include "per_flow_latency_window_stats_assert.svh"

module plws_checker import plws_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input plws_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input plws_out_t out_item_o
);

  `PLWS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `PLWS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o), "stalled result changed")
  // a sampled item keeps the input closed during its lookup step
  `PLWS_ASSERT_NEXT(a_busy_after_sample, in_valid_i && in_ready_o && in_item_i.sampled, !in_ready_o, "input open during lookup")
  // a fresh result is loaded only in a cycle that also opens the input
  `PLWS_ASSERT_IMPL(a_rise_ready, $rose(out_valid_o), $past(in_ready_o), "result appeared outside finish")
  `PLWS_ASSERT_IMPL(a_window_fields, out_valid_o && out_item_o.window_done, (out_item_o.window_samples != 8'd0) && !out_item_o.no_slot, "bad window report")

endmodule

bind per_flow_latency_window_stats plws_checker u_plws_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the per-flow latency window statistics block
module tb;
  import plws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready_o;
  plws_in_t   in_item   = '0;
  logic       out_valid_o;
  logic       out_ready = 1'b0;
  plws_out_t  out_item_o;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  per_flow_latency_window_stats i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // flow table mirror
  logic [7:0]  window_len = WINDOW_RESET;
  logic        flow_used  [SLOTS];
  plws_key_t   flow_key   [SLOTS];
  logic [7:0]  flow_count [SLOTS];
  logic [63:0] flow_e2e   [SLOTS];
  logic [63:0] flow_enc   [SLOTS];
  logic [63:0] flow_queue [SLOTS];
  logic [63:0] flow_send  [SLOTS];

  plws_in_t  pending_packets[$];
  plws_out_t expected_reports[$];
  plws_key_t flow_pool[32];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) flow_used[i] = 1'b0;
  end

  function automatic bit predict_latency_stats(input plws_in_t it, output plws_out_t r);
    int          hit;
    int          free_idx;
    plws_key_t   k;
    logic [63:0] e2e;
    logic [63:0] qw;
    logic [63:0] snd;
    r = '0;
    if (!it.sampled) return 1'b0;
    e2e = (it.tx_end_us >= it.capture_ts_us) ? it.tx_end_us - it.capture_ts_us : 64'd0;
    qw  = (it.tx_begin_us >= it.qin_ts_us) ? it.tx_begin_us - it.qin_ts_us : 64'd0;
    snd = it.tx_end_us - it.tx_begin_us;
    r.e2e_us        = e2e;
    r.queue_wait_us = qw;
    r.send_us       = snd;
    k.output_kind = it.output_kind;
    k.media_kind  = it.media_kind;
    k.output_id   = it.output_id;
    k.stream_id   = it.stream_id;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!flow_used[i]) begin
        if (free_idx < 0) free_idx = i;
      end else if (flow_key[i] == k) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) begin
      if (free_idx < 0) begin
        r.no_slot = 1'b1;
        return 1'b1;
      end
      hit = free_idx;
      flow_used[hit]  = 1'b1;
      flow_key[hit]   = k;
      flow_count[hit] = '0;
      flow_e2e[hit]   = '0;
      flow_enc[hit]   = '0;
      flow_queue[hit] = '0;
      flow_send[hit]  = '0;
    end
    r.slot_index = 5'(hit);
    flow_count[hit] = flow_count[hit] + 8'd1;
    flow_e2e[hit]   = flow_e2e[hit] + e2e;
    flow_enc[hit]   = flow_enc[hit] + it.encode_time_us;
    flow_queue[hit] = flow_queue[hit] + qw;
    flow_send[hit]  = flow_send[hit] + snd;
    if (flow_count[hit] >= window_len) begin
      r.window_done    = 1'b1;
      r.window_samples = flow_count[hit];
      r.sum_e2e_us     = flow_e2e[hit];
      r.sum_encode_us  = flow_enc[hit];
      r.sum_queue_us   = flow_queue[hit];
      r.sum_send_us    = flow_send[hit];
      flow_count[hit] = '0;
      flow_e2e[hit]   = '0;
      flow_enc[hit]   = '0;
      flow_queue[hit] = '0;
      flow_send[hit]  = '0;
    end
    return 1'b1;
  endfunction

  task automatic check_field(string fld, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, fld, exp_v, act_v);
    end
  endtask

  task automatic compare_report(plws_out_t e, plws_out_t a);
    check_field("e2e_us", e.e2e_us, a.e2e_us);
    check_field("queue_wait_us", e.queue_wait_us, a.queue_wait_us);
    check_field("send_us", e.send_us, a.send_us);
    check_field("slot_index", 64'(e.slot_index), 64'(a.slot_index));
    check_field("no_slot", 64'(e.no_slot), 64'(a.no_slot));
    check_field("window_done", 64'(e.window_done), 64'(a.window_done));
    check_field("window_samples", 64'(e.window_samples), 64'(a.window_samples));
    check_field("sum_e2e_us", e.sum_e2e_us, a.sum_e2e_us);
    check_field("sum_encode_us", e.sum_encode_us, a.sum_encode_us);
    check_field("sum_queue_us", e.sum_queue_us, a.sum_queue_us);
    check_field("sum_send_us", e.sum_send_us, a.sum_send_us);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n && (!in_valid || in_ready_o)) begin
      if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_packets.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a single long hold-off so the block backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: config and accepted items update the mirror, results are checked
  always @(posedge clk) begin
    plws_out_t r;
    if (rst_n) begin
      if (cfg_we) window_len = cfg_wdata;
      if (in_valid && in_ready_o) begin
        if (predict_latency_stats(in_item, r)) expected_reports.push_back(r);
      end
      if (out_valid_o && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result, slot %0d", $realtime, out_item_o.slot_index);
        end else begin
          compare_report(expected_reports.pop_front(), out_item_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic plws_key_t random_flow();
    plws_key_t k;
    k.output_kind = 2'($urandom_range(3));
    k.media_kind  = 2'($urandom_range(3));
    k.output_id   = 16'($urandom_range(65535));
    k.stream_id   = 16'($urandom_range(65535));
    return k;
  endfunction

  function automatic plws_in_t packet(plws_key_t k, logic smp, logic [63:0] cap,
                                      logic [63:0] enq, logic [63:0] sst,
                                      logic [63:0] sdn, logic [63:0] enc);
    plws_in_t it;
    it.sampled        = smp;
    it.output_kind    = k.output_kind;
    it.output_id      = k.output_id;
    it.stream_id      = k.stream_id;
    it.media_kind     = k.media_kind;
    it.capture_ts_us  = cap;
    it.qin_ts_us      = enq;
    it.tx_begin_us    = sst;
    it.tx_end_us      = sdn;
    it.encode_time_us = enc;
    return it;
  endfunction

  // mostly ordered timestamps with small gaps, otherwise anything goes
  function automatic plws_in_t random_packet(plws_key_t k, logic smp);
    logic [63:0] cap;
    logic [63:0] enq;
    logic [63:0] sst;
    if ($urandom_range(99) < 70) begin
      cap = rand64();
      enq = cap + $urandom_range(50000);
      sst = enq + $urandom_range(50000);
      return packet(k, smp, cap, enq, sst, sst + $urandom_range(50000),
                    64'($urandom_range(40000)));
    end
    return packet(k, smp, rand64(), rand64(), rand64(), rand64(), rand64());
  endfunction

  task automatic wait_idle();
    int calm;
    calm = 0;
    // an unsampled item may still be in flight
    while (calm < 4) begin
      @(posedge clk);
      if (pending_packets.size() != 0 || in_valid || out_valid_o ||
          expected_reports.size() != 0) calm = 0;
      else calm++;
    end
  endtask

  task automatic write_window(logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int phase_win[8]  = '{1, 8, 255, 3, 0, 30, 5, 2};
    int phase_len[8]  = '{150, 200, 300, 200, 150, 250, 200, 150};
    int phase_mode[8] = '{0, 1, 0, 2, 3, 1, 2, 3};
    int hot_pct;
    int taken;
    plws_key_t k;

    flow_pool[0] = '0;
    flow_pool[1] = '1;
    for (int i = 2; i < 32; i++) flow_pool[i] = random_flow();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and clamping at the reset window size
    pending_packets.push_back(packet(flow_pool[1], 1'b0, '1, '1, '1, '1, '1));
    for (int i = 0; i < 5; i++)
      pending_packets.push_back(packet(flow_pool[2], 1'b1, rand64(), rand64(), rand64(),
                                       rand64(), rand64()));
    pending_packets.push_back(packet(flow_pool[0], 1'b1, '0, '0, '0, '0, '0));
    pending_packets.push_back(packet(flow_pool[1], 1'b1, '0, '1, '0, '1, '1));
    pending_packets.push_back(packet(flow_pool[1], 1'b1, '1, '0, '1, '0, '0));
    pending_packets.push_back(packet(flow_pool[3], 1'b1, 64'd10, 64'd20, 64'd30, 64'd45,
                                     64'd7));
    wait_idle();
    // window shrunk below the count already gathered
    write_window(8'd3);
    pending_packets.push_back(random_packet(flow_pool[2], 1'b1));
    wait_idle();
    write_window(8'd1);
    pending_packets.push_back(random_packet(flow_pool[0], 1'b1));
    pending_packets.push_back(random_packet(flow_pool[3], 1'b1));
    wait_idle();
    write_window(8'd0);
    pending_packets.push_back(random_packet(flow_pool[0], 1'b1));
    pending_packets.push_back(random_packet(flow_pool[1], 1'b1));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_window(8'(phase_win[p]));
      case (phase_mode[p])
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      // one flow dominates while the window is at its widest
      hot_pct = (phase_win[p] == 255) ? 90 : 0;
      if (p == 6) hold_requests++;
      taken = 0;
      while (taken < phase_len[p]) begin
        if ($urandom_range(99) < 8) begin
          pending_packets.push_back(random_packet(random_flow(), 1'b0));
        end else begin
          if ($urandom_range(99) < hot_pct) k = flow_pool[2];
          else if ($urandom_range(99) < 85) k = flow_pool[$urandom_range(31)];
          else k = random_flow();
          pending_packets.push_back(random_packet(k, 1'b1));
          taken++;
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/plws_pkg.sv
rtl/core/plws_ram.sv
rtl/core/plws_slot_dir.sv
rtl/core/per_flow_latency_window_stats.sv
rtl/core/plws_checker.sv
tb/tb.sv
